>>> rtl/accsm_pkg.sv
// Package for the accelerometer sensor model: datapath widths, reset values
// of the configuration registers, register indexes and the lane control struct.
// Depends on nothing; every other file of the block imports it.
package accsm_pkg;

  localparam int unsigned DIGITS    = 16;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned IMU_W     = 41;
  localparam int unsigned W_W       = 42;
  localparam int unsigned V_W       = 60;
  localparam int unsigned FRAC_BITS = 36;
  localparam int unsigned ERR_SHIFT = 18;

  localparam logic [47:0] ROT_X_RST  = 48'd16384;
  localparam logic [47:0] ROT_Y_RST  = 48'd1073741824;
  localparam logic [47:0] ROT_Z_RST  = 48'd70368744177664;
  localparam logic [47:0] SENS_RST   = 48'd274882101312;
  localparam logic [31:0] LIMITS_RST = 32'd2147450880;
  localparam logic [19:0] PERIOD_RST = 20'd1000;

  typedef enum logic [2:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_SENS    = 3'd3,
    REG_NEUTRAL = 3'd4,
    REG_BIAS    = 3'd5,
    REG_LIMITS  = 3'd6,
    REG_PERIOD  = 3'd7
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ROT  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_SENS = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;
    logic rot_step;
    logic rot_last;
    logic sens_load;
    logic sens_step;
  } lane_ctrl_t;

endpackage

>>> rtl/accsm_lane.sv
// One axis of the accelerometer model: bit-serial rotation, bit-serial
// sensitivity scaling, rounding and clamping.
// Depends on accsm_pkg; the sequencing comes from the top level.
module accsm_lane import accsm_pkg::*; (
  input  logic              clk_i,
  input  lane_ctrl_t        ctrl_i,
  input  logic [47:0]       row_i,
  input  logic [2:0][23:0]  accel_i,
  input  logic [15:0]       noise_i,
  input  logic [15:0]       bias_i,
  input  logic [15:0]       neutral_i,
  input  logic [15:0]       sens_i,
  input  logic [15:0]       lim_lo_i,
  input  logic [15:0]       lim_hi_i,
  output logic [15:0]       reading_o
);

  localparam logic [V_W-1:0] RND_HALF = V_W'(64'd1 << (FRAC_BITS - 1));

  logic [15:0]              rot_q [3];
  logic signed [IMU_W-1:0]  mc_q [3];
  logic signed [IMU_W-1:0]  part [3];
  logic signed [IMU_W-1:0]  imu_q, imu_d;
  logic signed [16:0]       err_q, err_d;
  logic signed [W_W-1:0]    w_sum;
  logic [15:0]              sens_q;
  logic signed [V_W-1:0]    mc2_q, acc2_q, rnd_sum;
  logic signed [23:0]       rnd_cnt, lo_ext, hi_ext;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (rot_q[j][0]) begin
        part[j] = ctrl_i.rot_last ? -mc_q[j] : mc_q[j];
      end else begin
        part[j] = '0;
      end
    end
    imu_d = imu_q + part[0] + part[1] + part[2];
    err_d = $signed({bias_i[15], bias_i}) + $signed({noise_i[15], noise_i});
    w_sum = $signed({imu_q[IMU_W-1], imu_q})
          + $signed({{(W_W-17-ERR_SHIFT){err_q[16]}}, err_q, {ERR_SHIFT{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int j = 0; j < 3; j++) begin
        rot_q[j] <= row_i[16*j +: 16];
        mc_q[j]  <= $signed({{(IMU_W-24){accel_i[j][23]}}, accel_i[j]});
      end
      imu_q <= '0;
      err_q <= err_d;
    end else if (ctrl_i.rot_step) begin
      for (int j = 0; j < 3; j++) begin
        rot_q[j] <= rot_q[j] >> 1;
        mc_q[j]  <= mc_q[j] <<< 1;
      end
      imu_q <= imu_d;
    end
    if (ctrl_i.sens_load) begin
      mc2_q  <= $signed({{(V_W-W_W){w_sum[W_W-1]}}, w_sum});
      sens_q <= sens_i;
      acc2_q <= $signed({{(V_W-16-FRAC_BITS){neutral_i[15]}}, neutral_i,
                         {FRAC_BITS{1'b0}}});
    end else if (ctrl_i.sens_step) begin
      if (sens_q[0]) begin
        acc2_q <= acc2_q + mc2_q;
      end
      mc2_q  <= mc2_q <<< 1;
      sens_q <= sens_q >> 1;
    end
  end

  // Halves round away from zero: negative values take one less than a half.
  always_comb begin
    rnd_sum = acc2_q + $signed(RND_HALF) - $signed(V_W'(acc2_q[V_W-1]));
    rnd_cnt = rnd_sum[V_W-1:FRAC_BITS];
    lo_ext  = $signed({{8{lim_lo_i[15]}}, lim_lo_i});
    hi_ext  = $signed({{8{lim_hi_i[15]}}, lim_hi_i});
    priority if (rnd_cnt < lo_ext) begin
      reading_o = lim_lo_i;
    end else if (rnd_cnt > hi_ext) begin
      reading_o = lim_hi_i;
    end else begin
      reading_o = rnd_cnt[15:0];
    end
  end

endmodule

>>> rtl/accelerometer_sensor_model.sv
// Accelerometer sensor model: one request per simulation step, at most one
// reading per request. Holds the configuration registers, the next update time
// and the sequencer; depends on accsm_pkg and three accsm_lane instances.
//
// A request whose time is below the next update time is absorbed in the cycle
// it is accepted and gives no reading. A request that triggers an update is worked
// off in steps: ST_ROT runs bit-serially over the rotation coefficients, ST_PREP
// forms the scaled operand, ST_SENS runs bit-serially over the sensitivity, and
// ST_DONE rounds, clamps and loads the output register. All three axes work side
// by side. The input side is closed while a reading is in progress and opens
// again once it sits in the output register, so a new request can be taken while
// the reading still waits to be taken; updating requests never overlap. A full
// output register holds the sequencer in ST_DONE until it is free.
module accelerometer_sensor_model import accsm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_addr_i,
  input  logic [47:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // time_us, accel_x, accel_y, accel_z, noise_x, noise_y, noise_z
  input  logic [159:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // reading_x, reading_y, reading_z
  output logic [47:0]   m_axis_tdata
);

  logic [47:0] rot_x_q, rot_y_q, rot_z_q, sens_q, neutral_q, bias_q;
  logic [31:0] limits_q;
  logic [19:0] period_q;
  logic [40:0] next_q, next_d;
  state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        out_vld_q, out_vld_d;
  logic [47:0] out_q, out_d;
  logic        take, go, cnt_last;
  lane_ctrl_t  ctrl;
  logic [2:0][23:0] accel;
  logic [47:0] rows [3];
  logic [15:0] readings [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q   <= ROT_X_RST;
      rot_y_q   <= ROT_Y_RST;
      rot_z_q   <= ROT_Z_RST;
      sens_q    <= SENS_RST;
      neutral_q <= '0;
      bias_q    <= '0;
      limits_q  <= LIMITS_RST;
      period_q  <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_ROT_X:   rot_x_q   <= cfg_wdata_i;
        REG_ROT_Y:   rot_y_q   <= cfg_wdata_i;
        REG_ROT_Z:   rot_z_q   <= cfg_wdata_i;
        REG_SENS:    sens_q    <= cfg_wdata_i;
        REG_NEUTRAL: neutral_q <= cfg_wdata_i;
        REG_BIAS:    bias_q    <= cfg_wdata_i;
        REG_LIMITS:  limits_q  <= cfg_wdata_i[31:0];
        REG_PERIOD:  period_q  <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign take          = s_axis_tvalid && s_axis_tready;
  assign go            = take && ({1'b0, s_axis_tdata[39:0]} >= next_q);
  assign cnt_last      = (cnt_q == CNT_W'(DIGITS - 1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    next_d    = next_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_d     = out_q;
    ctrl      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (go) begin
          ctrl.load = 1'b1;
          next_d    = next_q + {21'd0, period_q};
          cnt_d     = '0;
          state_d   = ST_ROT;
        end
      end
      ST_ROT: begin
        ctrl.rot_step = 1'b1;
        ctrl.rot_last = cnt_last;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        ctrl.sens_load = 1'b1;
        cnt_d          = '0;
        state_d        = ST_SENS;
      end
      ST_SENS: begin
        ctrl.sens_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_d     = {readings[2], readings[1], readings[0]};
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      next_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      next_q    <= next_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  assign accel[0] = s_axis_tdata[63:40];
  assign accel[1] = s_axis_tdata[87:64];
  assign accel[2] = s_axis_tdata[111:88];
  assign rows[0]  = rot_x_q;
  assign rows[1]  = rot_y_q;
  assign rows[2]  = rot_z_q;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    accsm_lane u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .row_i     (rows[i]),
      .accel_i   (accel),
      .noise_i   (s_axis_tdata[112 + 16*i +: 16]),
      .bias_i    (bias_q[16*i +: 16]),
      .neutral_i (neutral_q[16*i +: 16]),
      .sens_i    (sens_q[16*i +: 16]),
      .lim_lo_i  (limits_q[15:0]),
      .lim_hi_i  (limits_q[31:16]),
      .reading_o (readings[i])
    );
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for accelerometer_sensor_model: drives update requests on the
// stream input, predicts each reading in a local model and compares it on the output.
// Depends on accsm_pkg and the RTL of accelerometer_sensor_model; nothing else.
`timescale 1ns / 100ps

module testbench import accsm_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic signed [15:0] noise_z;
    logic signed [15:0] noise_y;
    logic signed [15:0] noise_x;
    logic signed [23:0] accel_z;
    logic signed [23:0] accel_y;
    logic signed [23:0] accel_x;
    logic [39:0]        time_us;
  } sim_step_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } reading_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [2:0]   cfg_addr_i    = '0;
  logic [47:0]  cfg_wdata_i   = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;

  logic [47:0] cfg_shadow [8];
  logic [40:0] exp_next_us;
  reading_t    pending_readings [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_request  = 0;
  int          hold_left     = 0;
  int          idle_cycles   = 0;
  int          steps_sent    = 0;
  int          readings_seen = 0;
  int          cfg_writes    = 0;
  int          errors        = 0;
  string       axis_name [3] = '{"x", "y", "z"};

  accelerometer_sensor_model u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic reading_t predict_reading(sim_step_t s);
    logic signed [23:0] accel [3];
    logic signed [15:0] noise [3];
    logic [47:0]        rows [3];
    logic [15:0]        out [3];
    logic signed [15:0] coef, offset, bias, lo, hi;
    logic [15:0]        gain;
    longint             imu, v, cnt, half;
    reading_t           r;
    accel[0] = s.accel_x;
    accel[1] = s.accel_y;
    accel[2] = s.accel_z;
    noise[0] = s.noise_x;
    noise[1] = s.noise_y;
    noise[2] = s.noise_z;
    rows[0]  = cfg_shadow[REG_ROT_X];
    rows[1]  = cfg_shadow[REG_ROT_Y];
    rows[2]  = cfg_shadow[REG_ROT_Z];
    lo       = cfg_shadow[REG_LIMITS][15:0];
    hi       = cfg_shadow[REG_LIMITS][31:16];
    half     = longint'(1) <<< (FRAC_BITS - 1);
    for (int i = 0; i < 3; i++) begin
      imu = 0;
      for (int j = 0; j < 3; j++) begin
        coef = rows[i][16*j +: 16];
        imu += longint'(coef) * longint'(accel[j]);
      end
      gain   = cfg_shadow[REG_SENS][16*i +: 16];
      offset = cfg_shadow[REG_NEUTRAL][16*i +: 16];
      bias   = cfg_shadow[REG_BIAS][16*i +: 16];
      v = imu * longint'(gain);
      v += longint'(offset) <<< FRAC_BITS;
      v += ((longint'(bias) + longint'(noise[i])) * longint'(gain)) <<< (FRAC_BITS - ERR_SHIFT);
      if (v >= 0) begin
        cnt = (v + half) >>> FRAC_BITS;
      end else begin
        cnt = -((-v + half) >>> FRAC_BITS);
      end
      if (cnt < longint'(lo)) begin
        cnt = lo;
      end else if (cnt > longint'(hi)) begin
        cnt = hi;
      end
      out[i] = cnt[15:0];
    end
    r.x = out[0];
    r.y = out[1];
    r.z = out[2];
    return r;
  endfunction

  function automatic sim_step_t make_step(logic [39:0] t, int ax, int ay, int az,
                                          int nx, int ny, int nz);
    sim_step_t s;
    s.time_us = t;
    s.accel_x = ax[23:0];
    s.accel_y = ay[23:0];
    s.accel_z = az[23:0];
    s.noise_x = nx[15:0];
    s.noise_y = ny[15:0];
    s.noise_z = nz[15:0];
    return s;
  endfunction

  function automatic logic [39:0] pick_time(bit emit);
    logic [39:0] t;
    logic [40:0] span;
    t = 40'({$urandom, $urandom});
    if (exp_next_us > 41'h0FF_FFFF_FFFF) begin
      return 40'hFF_FFFF_FFFF;
    end
    if (emit) begin
      case ($urandom_range(0, 19))
        0: return ({1'b0, t} >= exp_next_us) ? t : exp_next_us[39:0];
        1: return 40'hFF_FFFF_FFFF;
        default: return exp_next_us[39:0] + 40'($urandom_range(0, 3));
      endcase
    end
    if (exp_next_us == 0) begin
      return 40'd0;
    end
    if ($urandom_range(0, 4) == 0) begin
      return 40'({1'b0, t} % exp_next_us);
    end
    span = (exp_next_us > 41'd5000) ? 41'd4999 : exp_next_us - 1;
    return 40'(exp_next_us - 1 - 41'($urandom_range(0, int'(span))));
  endfunction

  function automatic sim_step_t random_step();
    sim_step_t   s;
    logic [23:0] a [3];
    logic [15:0] n [3];
    for (int i = 0; i < 3; i++) begin
      a[i] = 24'($urandom);
      n[i] = 16'($urandom);
      if ($urandom_range(0, 7) != 0) begin
        a[i] = $signed(a[i]) >>> $urandom_range(0, 10);
        n[i] = $signed(n[i]) >>> $urandom_range(0, 6);
      end
    end
    s.time_us = pick_time($urandom_range(0, 3) != 0);
    s.accel_x = a[0];
    s.accel_y = a[1];
    s.accel_z = a[2];
    s.noise_x = n[0];
    s.noise_y = n[1];
    s.noise_z = n[2];
    return s;
  endfunction

  function automatic logic [15:0] mix16();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] mix_gain();
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2, 3, 4, 5: return 16'($urandom_range(32, 512));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [47:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_LIMITS: cfg_shadow[idx] = {16'h0, value[31:0]};
      REG_PERIOD: cfg_shadow[idx] = {28'h0, value[19:0]};
      default:    cfg_shadow[idx] = value;
    endcase
    cfg_writes++;
  endtask

  // Offers one request, waits for its acceptance and records the expected reading when it triggers an update.
  task automatic send_step(sim_step_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    if ({1'b0, s.time_us} >= exp_next_us) begin
      pending_readings.push_back(predict_reading(s));
      exp_next_us = exp_next_us + 41'(cfg_shadow[REG_PERIOD]);
    end
    steps_sent++;
    @(negedge clk_i);
  endtask

  task automatic finish_burst();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_config();
    logic [15:0] lo, hi;
    write_reg(REG_ROT_X, {mix16(), mix16(), mix16()});
    write_reg(REG_ROT_Y, {mix16(), mix16(), mix16()});
    write_reg(REG_ROT_Z, {mix16(), mix16(), mix16()});
    write_reg(REG_SENS, {mix_gain(), mix_gain(), mix_gain()});
    write_reg(REG_NEUTRAL, {mix16(), mix16(), mix16()});
    write_reg(REG_BIAS, {mix16(), mix16(), mix16()});
    lo = 16'h8000;
    hi = 16'h7FFF;
    case ($urandom_range(0, 3))
      0: begin
        lo = 16'($urandom);
        hi = 16'($urandom);
      end
      1: begin
        lo = -16'($urandom_range(0, 2000));
        hi = 16'($urandom_range(0, 2000));
      end
      default: ;
    endcase
    write_reg(REG_LIMITS, {16'($urandom), hi, lo});
    case ($urandom_range(0, 7))
      0: write_reg(REG_PERIOD, {28'($urandom), 20'd0});
      1: write_reg(REG_PERIOD, {28'($urandom), 20'd1000000});
      2: write_reg(REG_PERIOD, 48'd1);
      default: write_reg(REG_PERIOD, 48'($urandom_range(1, 5000)));
    endcase
  endtask

  task automatic test_reset_defaults();
    send_step(make_step(40'd0, 0, 0, 0, 0, 0, 0));
    send_step(make_step(40'd999, 1, 2, 3, 4, 5, 6));
    send_step(make_step(40'd1000, 8388607, -8388608, 65536, 32767, -32768, 0));
    send_step(make_step(40'hFF_FFFF_FFFF, 123456, -654321, 7, -7, 100, -100));
    send_step(make_step(40'd2500, 5, 5, 5, 5, 5, 5));
    // Exact halves of a count round away from zero.
    send_step(make_step(40'd3000, 32768, -32768, 32767, 0, 0, 0));
    finish_burst();
  endtask

  task automatic test_extreme_config();
    write_reg(REG_ROT_X, {16'h8000, 16'h8000, 16'h8000});
    write_reg(REG_ROT_Y, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(REG_ROT_Z, {16'h0001, 16'hC000, 16'h4000});
    write_reg(REG_SENS, {16'h0040, 16'h0000, 16'hFFFF});
    write_reg(REG_NEUTRAL, {16'h0000, 16'h7FFF, 16'h8000});
    write_reg(REG_BIAS, {16'h1000, 16'h8000, 16'h7FFF});
    // With a zero period every request at or past the update time gives a reading.
    write_reg(REG_PERIOD, 48'd0);
    send_step(make_step(exp_next_us[39:0], -8388608, -8388608, -8388608, -32768, -32768, -32768));
    send_step(make_step(exp_next_us[39:0], 8388607, 8388607, 8388607, 32767, 32767, 32767));
    send_step(make_step(exp_next_us[39:0] - 1, 1, 1, 1, 1, 1, 1));
    send_step(make_step(exp_next_us[39:0], 8388607, -8388608, 0, -32768, 32767, 0));
    send_step(make_step(exp_next_us[39:0], 0, 0, 0, 0, 0, 0));
    send_step(make_step(exp_next_us[39:0] + 7, -1, 1, -1, 1, -1, 1));
    finish_burst();
  endtask

  task automatic test_inverted_limits();
    write_reg(REG_ROT_X, ROT_X_RST);
    write_reg(REG_ROT_Y, ROT_Y_RST);
    write_reg(REG_ROT_Z, ROT_Z_RST);
    write_reg(REG_SENS, SENS_RST);
    write_reg(REG_NEUTRAL, 48'd0);
    write_reg(REG_BIAS, 48'd0);
    write_reg(REG_PERIOD, 48'd1000);
    // Minimum 50 above maximum -50: the minimum test wins.
    write_reg(REG_LIMITS, {16'h0, 16'hFFCE, 16'h0032});
    send_step(make_step(exp_next_us[39:0], -6553600, 0, 6553600, 0, 0, 0));
    send_step(make_step(exp_next_us[39:0], 3276800, 6553600, -6553600, 0, 0, 0));
    finish_burst();
    write_reg(REG_LIMITS, {16'h0, 16'h0014, 16'hFFEC});
    send_step(make_step(exp_next_us[39:0], -6553600, 327680, 6553600, 0, 0, 0));
    send_step(make_step(exp_next_us[39:0], 1310720, -1310720, 1277952, 0, 0, 0));
    send_step(make_step(exp_next_us[39:0] + 5, 0, 0, 0, 32767, -32768, 4096));
    finish_burst();
  endtask

  task automatic test_random_traffic(int bursts, int steps);
    for (int b = 0; b < bursts; b++) begin
      random_config();
      for (int k = 0; k < steps; k++) begin
        send_step(random_step());
      end
      finish_burst();
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // block fills up and closes its input.
  task automatic test_backpressure();
    random_config();
    write_reg(REG_PERIOD, 48'd10);
    hold_request = HOLD_CYCLES;
    for (int k = 0; k < 60; k++) begin
      send_step(random_step());
    end
    finish_burst();
  endtask

  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_readings
    reading_t           exp_r, got_r;
    logic signed [15:0] exp_a [3];
    logic signed [15:0] got_a [3];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r = m_axis_tdata;
      readings_seen++;
      if (pending_readings.size() == 0) begin
        $display("%0t: reading %h arrived with none expected", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_r = pending_readings.pop_front();
        exp_a = '{exp_r.x, exp_r.y, exp_r.z};
        got_a = '{got_r.x, got_r.y, got_r.z};
        for (int i = 0; i < 3; i++) begin
          if (exp_a[i] !== got_a[i]) begin
            $display("%0t: reading_%s expected %0d, got %0d",
                     $time, axis_name[i], exp_a[i], got_a[i]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** accelerometer_sensor_model: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_shadow[REG_ROT_X]   = ROT_X_RST;
    cfg_shadow[REG_ROT_Y]   = ROT_Y_RST;
    cfg_shadow[REG_ROT_Z]   = ROT_Z_RST;
    cfg_shadow[REG_SENS]    = SENS_RST;
    cfg_shadow[REG_NEUTRAL] = '0;
    cfg_shadow[REG_BIAS]    = '0;
    cfg_shadow[REG_LIMITS]  = {16'h0, LIMITS_RST};
    cfg_shadow[REG_PERIOD]  = {28'h0, PERIOD_RST};
    exp_next_us = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_extreme_config();
    test_inverted_limits();
    send_idle_pct = 28;
    recv_idle_pct = 68;
    test_random_traffic(4, 120);
    send_idle_pct = 68;
    recv_idle_pct = 28;
    test_random_traffic(4, 120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_traffic(3, 120);

    $display("Covered %0d update requests and %0d checked readings over %0d register writes,",
             steps_sent, readings_seen, cfg_writes);
    $display("including extreme, inverted-limit and zero-period settings; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("** accelerometer_sensor_model: PASSED **");
    end else begin
      $display("** accelerometer_sensor_model: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/accsm_pkg.sv
rtl/accsm_lane.sv
rtl/accelerometer_sensor_model.sv
dv/testbench.sv
